[src/sssb_pkg.sv]
// ----------------------------------------------------------------------------
// sssb_pkg
// Shared types, constants and tables of the seven-segment scan/blink block.
// ----------------------------------------------------------------------------
package sssb_pkg;

    localparam int DIGITS_MAX_DEF = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIGIT_COUNT    = 3'd0,
        CFG_BLINK_FIRST    = 3'd1,
        CFG_BLINK_LAST     = 3'd2,
        CFG_BLINK_HALF     = 3'd3,
        CFG_DP_BLINK_FIRST = 3'd4,
        CFG_DP_BLINK_LAST  = 3'd5,
        CFG_DP_BLINK_HALF  = 3'd6,
        CFG_DP_ENABLE_MASK = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [3:0] digit_count;
        logic [2:0] blink_first;
        logic [2:0] blink_last;
        logic [7:0] blink_half;
        logic [2:0] dp_first;
        logic [2:0] dp_last;
        logic [7:0] dp_half;
        logic [7:0] dp_mask;
    } cfg_t;

    typedef struct packed {
        logic blink_clr;
        logic dp_clr;
    } cfg_evt_t;

    // (scan + 1) mod count, indexed by {scan, count}; count of zero maps to 0
    typedef logic [255:0][3:0] wrap_tab_t;

    function automatic wrap_tab_t build_wrap();
        wrap_tab_t tab;
        int        v;
        for (int s = 0; s < 16; s++) begin
            for (int c = 0; c < 16; c++) begin
                v = s + 1;
                if (c == 0) begin
                    v = 0;
                end else begin
                    for (int k = 0; k < 17; k++) begin
                        if (v >= c) begin
                            v = v - c;
                        end
                    end
                end
                tab[s * 16 + c] = 4'(v);
            end
        end
        return tab;
    endfunction

    localparam wrap_tab_t SCAN_WRAP = build_wrap();

    function automatic logic [6:0] seg_decode(input logic [3:0] code);
        logic [6:0] img;
        case (code)
            4'd0:    img = 7'h3F;
            4'd1:    img = 7'h06;
            4'd2:    img = 7'h5B;
            4'd3:    img = 7'h4F;
            4'd4:    img = 7'h66;
            4'd5:    img = 7'h6D;
            4'd6:    img = 7'h7D;
            4'd7:    img = 7'h07;
            4'd8:    img = 7'h7F;
            4'd9:    img = 7'h6F;
            default: img = 7'h00;
        endcase
        return img;
    endfunction

endpackage

[src/sssb_cfg.sv]
// ----------------------------------------------------------------------------
// sssb_cfg
// Configuration register file with range checks and phase-clear strobes.
// ----------------------------------------------------------------------------
module sssb_cfg #(
    parameter int DIGITS_MAX = sssb_pkg::DIGITS_MAX_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [sssb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sssb_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output sssb_pkg::cfg_t                  cfg,
    output sssb_pkg::cfg_evt_t              evt
);
    import sssb_pkg::*;

    localparam logic [3:0] COUNT_RST = (DIGITS_MAX < 8) ? 4'(DIGITS_MAX) : 4'd8;

    cfg_t       cfg_reg, cfg_next;
    logic [3:0] cnt_wr;
    logic [2:0] rng_wr;
    logic       rng_ok;

    assign cnt_wr = cfg_wdata[3:0];
    assign rng_wr = cfg_wdata[2:0];
    assign rng_ok = 32'(rng_wr) < DIGITS_MAX;

    always_comb begin
        cfg_next = cfg_reg;
        evt      = '0;
        if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_DIGIT_COUNT: begin
                    if (cnt_wr != 4'd0) begin
                        cfg_next.digit_count = (32'(cnt_wr) > DIGITS_MAX) ?
                                               4'(DIGITS_MAX) : cnt_wr;
                    end
                end
                CFG_BLINK_FIRST: begin
                    if (rng_ok) cfg_next.blink_first = rng_wr;
                end
                CFG_BLINK_LAST: begin
                    if (rng_ok) cfg_next.blink_last = rng_wr;
                end
                CFG_BLINK_HALF: begin
                    cfg_next.blink_half = cfg_wdata;
                    evt.blink_clr       = 1'b1;
                end
                CFG_DP_BLINK_FIRST: begin
                    if (rng_ok) cfg_next.dp_first = rng_wr;
                end
                CFG_DP_BLINK_LAST: begin
                    if (rng_ok) cfg_next.dp_last = rng_wr;
                end
                CFG_DP_BLINK_HALF: begin
                    cfg_next.dp_half = cfg_wdata;
                    evt.dp_clr       = 1'b1;
                end
                CFG_DP_ENABLE_MASK: begin
                    cfg_next.dp_mask = cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg             <= '0;
            cfg_reg.digit_count <= COUNT_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[src/sssb_core.sv]
// ----------------------------------------------------------------------------
// sssb_core
// Digit image store, scan index, blink phases and segment composition.
// ----------------------------------------------------------------------------
module sssb_core #(
    parameter int DIGITS_MAX = sssb_pkg::DIGITS_MAX_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  logic               cmd,
    input  logic [31:0]        bcd_digits,
    input  logic [3:0]         digit_total,
    input  sssb_pkg::cfg_t     cfg,
    input  sssb_pkg::cfg_evt_t evt,
    output logic [2:0]         digit_select,
    output logic [7:0]         segments
);
    import sssb_pkg::*;

    localparam int IW = (DIGITS_MAX > 1) ? $clog2(DIGITS_MAX) : 1;

    logic [IW-1:0] scan_reg, scan_next;
    logic [6:0]    img_reg [DIGITS_MAX];
    logic [6:0]    img_next [DIGITS_MAX];
    logic [8:0]    blink_phase_reg, blink_phase_next;
    logic [8:0]    dp_phase_reg, dp_phase_next;
    logic [3:0]    wrap;
    logic          wrapped;
    logic [3:0]    wr_total;
    logic [8:0]    blink_adv, dp_adv;
    logic [6:0]    img_sel;
    logic          dig_blank, dp_blank, dp_lit;
    logic [4:0]    d5;

    assign wr_total = (digit_total > cfg.digit_count) ? cfg.digit_count : digit_total;

    for (genvar i = 0; i < DIGITS_MAX; i++) begin : g_img
        if (i < 8) begin : g_nib
            assign img_next[i] = (4'(i) < wr_total) ?
                                 seg_decode(bcd_digits[4*i +: 4]) : 7'h00;
        end else begin : g_none
            assign img_next[i] = 7'h00;
        end
    end

    always_comb begin
        wrap      = SCAN_WRAP[{4'(scan_reg), cfg.digit_count}];
        scan_next = IW'(wrap);
        wrapped   = (wrap == 4'd0);

        blink_adv = blink_phase_reg;
        if (cfg.blink_half != 8'd0) begin
            blink_adv = (blink_phase_reg + 9'd1 == {cfg.blink_half, 1'b0}) ?
                        9'd0 : blink_phase_reg + 9'd1;
        end
        dp_adv = dp_phase_reg;
        if (cfg.dp_half != 8'd0) begin
            dp_adv = (dp_phase_reg + 9'd1 == {cfg.dp_half, 1'b0}) ?
                     9'd0 : dp_phase_reg + 9'd1;
        end
        blink_phase_next = wrapped ? blink_adv : blink_phase_reg;
        dp_phase_next    = wrapped ? dp_adv : dp_phase_reg;
    end

    // result for the tick being taken, from the advanced state
    always_comb begin
        d5        = 5'(scan_next);
        img_sel   = img_reg[scan_next];
        dig_blank = (cfg.blink_half != 8'd0) &&
                    (blink_phase_next < {1'b0, cfg.blink_half}) &&
                    (d5 >= 5'(cfg.blink_first)) && (d5 <= 5'(cfg.blink_last));
        dp_blank  = (cfg.dp_half != 8'd0) &&
                    (dp_phase_next < {1'b0, cfg.dp_half}) &&
                    (d5 >= 5'(cfg.dp_first)) && (d5 <= 5'(cfg.dp_last));
        dp_lit    = (d5 < 5'd8) && cfg.dp_mask[d5[2:0]];

        digit_select = 3'(scan_next);
        segments     = {dp_lit && !dp_blank, dig_blank ? 7'h00 : img_sel};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg        <= '0;
            blink_phase_reg <= '0;
            dp_phase_reg    <= '0;
            for (int i = 0; i < DIGITS_MAX; i++) begin
                img_reg[i] <= '0;
            end
        end else begin
            if (step_en && !cmd) begin
                scan_reg        <= scan_next;
                blink_phase_reg <= blink_phase_next;
                dp_phase_reg    <= dp_phase_next;
            end
            if (step_en && cmd) begin
                for (int i = 0; i < DIGITS_MAX; i++) begin
                    img_reg[i] <= img_next[i];
                end
            end
            if (evt.blink_clr) blink_phase_reg <= '0;
            if (evt.dp_clr)    dp_phase_reg    <= '0;
        end
    end

    a_scan_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !(step_en && !cmd) |=> $stable(scan_reg))
        else $error("scan index moved without a tick");

    a_blink_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg.blink_half == 8'd0) || (blink_phase_reg < {cfg.blink_half, 1'b0}))
        else $error("digit blink phase out of period");

    a_dp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg.dp_half == 8'd0) || (dp_phase_reg < {cfg.dp_half, 1'b0}))
        else $error("point blink phase out of period");

endmodule

[src/seven_segment_scan_blink.sv]
// ----------------------------------------------------------------------------
// seven_segment_scan_blink
// Multiplexed seven-segment scanner with digit and decimal-point blinking.
//
//   group  dir  fields (lowest bit first)                   beat gives
//   s_     in   tdata: bcd_digits[31:0], digit_total[35:32]  write or tick
//                tuser: cmd (1 write, 0 tick)
//   m_     out  tdata: digit_select[2:0], segments[10:3]     one per tick
//   cfg_   in   cfg_index, cfg_wdata, cfg_we                 register write
//
// One beat per cycle sustained while m_ is not stalled; a tick beat passes
// through the input register, then the result register, before it shows on m_.
// Write beats produce no output beat.
// Reset: synchronous, aresetn low; config to defaults, images blank.
// A stalled m_ side holds ticks in the input register; writes still drain.
// ----------------------------------------------------------------------------
module seven_segment_scan_blink #(
    parameter int DIGITS_MAX = sssb_pkg::DIGITS_MAX_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [39:0]                     s_tdata,   // bcd_digits, digit_total
    input  logic                            s_tuser,   // cmd
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // digit_select, segments
    input  logic                            cfg_we,
    input  logic [sssb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sssb_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import sssb_pkg::*;

    cfg_t       cfg;
    cfg_evt_t   evt;

    logic       in_valid_reg, in_valid_next;
    logic       in_cmd_reg;
    logic [31:0] in_bcd_reg;
    logic [3:0] in_total_reg;
    logic       adv;
    logic       m_valid_reg, m_valid_next;
    logic [10:0] m_data_reg;
    logic [2:0] res_digit;
    logic [7:0] res_seg;

    sssb_cfg #(
        .DIGITS_MAX (DIGITS_MAX)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .evt       (evt)
    );

    sssb_core #(
        .DIGITS_MAX (DIGITS_MAX)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_en      (adv),
        .cmd          (in_cmd_reg),
        .bcd_digits   (in_bcd_reg),
        .digit_total  (in_total_reg),
        .cfg          (cfg),
        .evt          (evt),
        .digit_select (res_digit),
        .segments     (res_seg)
    );

    assign adv      = in_valid_reg && (in_cmd_reg || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (adv) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (adv && !in_cmd_reg) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg   <= s_tuser;
            in_bcd_reg   <= s_tdata[31:0];
            in_total_reg <= s_tdata[35:32];
        end
        if (adv && !in_cmd_reg) begin
            m_data_reg <= {res_seg, res_digit};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_data_reg};

    a_out_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(adv && !in_cmd_reg))
        else $error("output beat without a tick");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !(adv && !in_cmd_reg))
        else $error("pending output beat overwritten");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !adv) |=> (in_valid_reg && $stable(in_bcd_reg)
                                    && $stable(in_cmd_reg)))
        else $error("stalled input register changed");

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the seven-segment scan/blink block. Write and tick beats are
// streamed in with random gaps while the result side stalls at random. A
// cycle-free predictor tracks digit images, the scan position and both blink
// phases, and every result beat is checked field by field against it. Short
// directed tests come first, then phases of random traffic, each phase under
// a fresh register setting.
// ----------------------------------------------------------------------------
module tb;

    import sssb_pkg::*;

    localparam int NDIG = DIGITS_MAX_DEF;
    localparam logic [6:0] GLYPH [10] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                          7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F};

    typedef struct {
        logic [2:0] sel;
        logic [7:0] seg;
    } scan_beat_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [39:0]           s_tdata   = '0;   // bcd_digits[31:0], digit_total[35:32]
    logic                  s_tuser   = 1'b0; // cmd
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;          // digit_select[2:0], segments[10:3]
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // predictor state
    cfg_t       shadow;
    logic [3:0] scan_pos;
    logic [6:0] images [NDIG];
    logic [8:0] dig_phase;
    logic [8:0] dp_phase;

    scan_beat_t pending_scans [$];
    int         n_fail      = 0;
    bit         tx_idle_en  = 1'b1;
    bit         rx_stall_en = 1'b1;
    int         rx_hold     = 0;

    seven_segment_scan_blink i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    function automatic logic [8:0] next_phase(input logic [8:0] ph, input logic [7:0] half);
        int period;
        period = 2 * int'(half);
        if (period == 0) begin
            return ph;
        end
        return 9'((int'(ph) + 1) % period);
    endfunction

    function automatic bit dark(input logic [8:0] ph, input logic [7:0] half,
                                input logic [2:0] first, input logic [2:0] last,
                                input logic [2:0] d);
        return half != 0 && ph < half && d >= first && d <= last;
    endfunction

    function automatic scan_beat_t predict_scan();
        scan_beat_t b;
        logic [2:0] d;
        logic [7:0] seg;
        scan_pos = 4'((int'(scan_pos) + 1) % int'(shadow.digit_count));
        if (scan_pos == 0) begin
            dig_phase = next_phase(dig_phase, shadow.blink_half);
            dp_phase  = next_phase(dp_phase, shadow.dp_half);
        end
        d   = scan_pos[2:0];
        seg = {1'b0, images[d]};
        if (dark(dig_phase, shadow.blink_half, shadow.blink_first, shadow.blink_last, d)) begin
            seg = '0;
        end
        if (shadow.dp_mask[d]) begin
            seg[7] = 1'b1;
        end
        if (dark(dp_phase, shadow.dp_half, shadow.dp_first, shadow.dp_last, d)) begin
            seg[7] = 1'b0;
        end
        b.sel = d;
        b.seg = seg;
        return b;
    endfunction

    task automatic flag(input string what, input int want_v, input int got_v);
        n_fail++;
        if (n_fail <= 10) begin
            $display("mismatch %s: expected %0h, got %0h", what, want_v, got_v);
        end
    endtask

    // one beat on the input side, with an optional gap in front
    task automatic send_beat(input bit is_write, input logic [31:0] codes,
                             input logic [3:0] total);
        int         gap;
        int         lim;
        logic [3:0] code;
        @(negedge aclk);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 8);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_write;
        s_tdata  <= {4'b0, total, codes};
        do @(posedge aclk); while (s_tready !== 1'b1);
        if (is_write) begin
            lim = (total > shadow.digit_count) ? int'(shadow.digit_count) : int'(total);
            for (int i = 0; i < NDIG; i++) begin
                code      = codes[4*i +: 4];
                images[i] = (i < lim && code < 10) ? GLYPH[code] : 7'h00;
            end
        end else begin
            pending_scans.push_back(predict_scan());
        end
    endtask

    // stop sending, let every result land, then let writes in flight drain
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_scans.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [7:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_DIGIT_COUNT: begin
                if (val[3:0] != 0) begin
                    shadow.digit_count = (val[3:0] > NDIG) ? 4'(NDIG) : val[3:0];
                end
            end
            CFG_BLINK_FIRST:    shadow.blink_first = val[2:0];
            CFG_BLINK_LAST:     shadow.blink_last  = val[2:0];
            CFG_BLINK_HALF: begin
                shadow.blink_half = val;
                dig_phase         = '0;
            end
            CFG_DP_BLINK_FIRST: shadow.dp_first = val[2:0];
            CFG_DP_BLINK_LAST:  shadow.dp_last  = val[2:0];
            CFG_DP_BLINK_HALF: begin
                shadow.dp_half = val;
                dp_phase       = '0;
            end
            CFG_DP_ENABLE_MASK: shadow.dp_mask = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic pick_range(input cfg_idx_t lo_idx, input cfg_idx_t hi_idx);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'($urandom);
        hi = 8'($urandom);
        lo[2:0] = 3'($urandom_range(0, 7));
        hi[2:0] = 3'($urandom_range(lo[2:0], 7));
        if ($urandom_range(0, 4) == 0) begin
            lo[2:0] = 3'($urandom_range(1, 7));
            hi[2:0] = 3'($urandom_range(0, lo[2:0] - 1));
        end
        write_reg(lo_idx, lo);
        write_reg(hi_idx, hi);
    endtask

    task automatic pick_half(input cfg_idx_t idx);
        case ($urandom_range(0, 5))
            0:       write_reg(idx, 8'h00);
            1:       write_reg(idx, 8'hFF);
            2:       write_reg(idx, 8'h01);
            default: write_reg(idx, 8'($urandom_range(1, 3)));
        endcase
    endtask

    task automatic shuffle_config();
        logic [7:0] val;
        val = 8'($urandom);
        case ($urandom_range(0, 5))
            0:       val[3:0] = 4'd0;
            1:       val[3:0] = 4'd1;
            2:       val[3:0] = 4'd8;
            3:       val[3:0] = 4'($urandom_range(9, 15));
            default: val[3:0] = 4'($urandom_range(1, 8));
        endcase
        write_reg(CFG_DIGIT_COUNT, val);
        pick_range(CFG_BLINK_FIRST, CFG_BLINK_LAST);
        pick_half(CFG_BLINK_HALF);
        pick_range(CFG_DP_BLINK_FIRST, CFG_DP_BLINK_LAST);
        pick_half(CFG_DP_BLINK_HALF);
        case ($urandom_range(0, 3))
            0:       write_reg(CFG_DP_ENABLE_MASK, 8'h00);
            1:       write_reg(CFG_DP_ENABLE_MASK, 8'hFF);
            default: write_reg(CFG_DP_ENABLE_MASK, 8'($urandom));
        endcase
    endtask

    // BCD decode, over-long totals and the blank codes 10 to 15
    task automatic test_decode();
        send_beat(1'b1, 32'h7654_3210, 4'd8);
        repeat (8) send_beat(1'b0, 32'hFFFF_FFFF, 4'hF);
        send_beat(1'b1, 32'hFEDC_BA98, 4'd15);
        repeat (4) send_beat(1'b0, 32'h0, 4'h0);
    endtask

    // zero count ignored, oversized count saturated, short write blanks the rest
    task automatic test_digit_count();
        wait_idle();
        write_reg(CFG_DIGIT_COUNT, 8'hF0);
        write_reg(CFG_DIGIT_COUNT, 8'h0F);
        write_reg(CFG_DIGIT_COUNT, 8'h03);
        send_beat(1'b1, 32'h0000_0999, 4'd2);
        repeat (3) send_beat(1'b0, 32'h0, 4'h0);
    endtask

    // digit and point blinking over two short scans
    task automatic test_blink();
        wait_idle();
        write_reg(CFG_BLINK_FIRST, 8'h01);
        write_reg(CFG_BLINK_LAST, 8'h02);
        write_reg(CFG_BLINK_HALF, 8'h01);
        write_reg(CFG_DP_ENABLE_MASK, 8'hA5);
        write_reg(CFG_DP_BLINK_FIRST, 8'h00);
        write_reg(CFG_DP_BLINK_LAST, 8'hFF);
        write_reg(CFG_DP_BLINK_HALF, 8'h01);
        send_beat(1'b1, 32'h0000_0123, 4'd3);
        repeat (6) send_beat(1'b0, 32'h0, 4'h0);
    endtask

    task automatic test_random();
        logic [31:0] codes;
        logic [3:0]  total;
        for (int p = 0; p < 7; p++) begin
            wait_idle();
            shuffle_config();
            tx_idle_en  = (p < 6) && $urandom_range(0, 3) != 0;
            rx_stall_en = (p < 6) && $urandom_range(0, 3) != 0;
            for (int i = 0; i < 130; i++) begin
                if ($urandom_range(0, 6) == 0) begin
                    codes = $urandom;
                    if ($urandom_range(0, 1) == 0) begin
                        for (int k = 0; k < 8; k++) begin
                            codes[4*k +: 4] = 4'($urandom_range(0, 9));
                        end
                    end
                    total = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(9, 15))
                                                        : 4'($urandom_range(0, 8));
                    send_beat(1'b1, codes, total);
                end else begin
                    send_beat(1'b0, $urandom, 4'($urandom));
                end
            end
        end
    endtask

    // result side: random stall bursts
    always @(negedge aclk) begin
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold--;
        end else if (rx_stall_en && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            rx_hold = $urandom_range(1, 8) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_scan
        scan_beat_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_scans.size() == 0) begin
                flag("unexpected beat", 0, int'(m_tdata));
            end else begin
                want = pending_scans.pop_front();
                if (m_tdata[2:0] !== want.sel) begin
                    flag("digit_select", int'(want.sel), int'(m_tdata[2:0]));
                end
                if (m_tdata[10:3] !== want.seg) begin
                    flag("segments", int'(want.seg), int'(m_tdata[10:3]));
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin
        shadow = '{digit_count: 4'(NDIG), default: '0};
        scan_pos  = '0;
        dig_phase = '0;
        dp_phase  = '0;
        for (int i = 0; i < NDIG; i++) begin
            images[i] = '0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_decode();
        test_digit_count();
        test_blink();
        test_random();
        wait_idle();

        n_fail += pending_scans.size();
        if (n_fail == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
